### hw/rtl/page_bitmap_blitter_assert.svh
// Assertion macros for the page bitmap blitter.
// Used by modules that carry i_clk and i_rst_n; no other dependencies.
`ifndef PAGE_BITMAP_BLITTER_ASSERT_SVH
`define PAGE_BITMAP_BLITTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PBB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pbb_pkg.sv
// Shared types, constants and the blend function of the page bitmap blitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package pbb_pkg;

    localparam int FB_COLUMNS_DEF = 128;
    localparam int FB_ROWS_DEF    = 64;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    localparam logic ACT_BLIT = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [2:0] CFG_POS_X         = 3'd0;
    localparam logic [2:0] CFG_POS_Y         = 3'd1;
    localparam logic [2:0] CFG_BITMAP_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_BITMAP_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_BLEND_MODE    = 3'd4;

    localparam logic [2:0] BLEND_REPLACE = 3'd0;
    localparam logic [2:0] BLEND_OR      = 3'd1;
    localparam logic [2:0] BLEND_ERASE   = 3'd2;
    localparam logic [2:0] BLEND_XOR     = 3'd3;
    localparam logic [2:0] BLEND_AND     = 3'd4;
    localparam logic [2:0] BLEND_NOT     = 3'd5;
    localparam logic [2:0] BLEND_XNOR    = 3'd6;

    typedef struct packed {
        logic       action;
        logic [7:0] src_column;
        logic [4:0] src_page;
        logic [7:0] bitmap_byte;
        logic [6:0] read_column;
        logic [2:0] read_page;
    } t_in_item;

    typedef struct packed {
        logic [6:0] fb_column;
        logic [2:0] fb_page;
        logic [7:0] fb_byte;
        logic       is_readback;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       is_read;
        logic       oob;
        logic [4:0] page;
        logic [7:0] column;
        logic [7:0] data;
        logic [7:0] mask;
        logic       last;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] pbb_blend(input logic [2:0] mode, input logic [7:0] o,
                                             input logic [7:0] d, input logic [7:0] m);
        logic [7:0] r;
        unique case (mode)
            BLEND_OR:    r = o | (d & m);
            BLEND_ERASE: r = o & ~(d & m);
            BLEND_XOR:   r = o ^ (d & m);
            BLEND_AND:   r = o & (~m | d);
            BLEND_NOT:   r = o | (~d & m);
            BLEND_XNOR:  r = o ^ (~d & m);
            default:     r = (o & ~m) | (d & m);
        endcase
        return r & FULL_BYTE;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pbb_front.sv
// Front end: configuration registers, item intake, clipping and page split.
// Depends on pbb_pkg; feeds pbb_queue with byte operations.
`default_nettype none

module pbb_front
    import pbb_pkg::*;
#(
    parameter int FB_COLUMNS = FB_COLUMNS_DEF,
    parameter int FB_ROWS    = FB_ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    input  wire logic       i_clearing,
    input  wire t_q_stat    i_q_stat,
    output t_q_push         o_push,
    output logic [2:0]      o_blend_mode
);

    localparam int FB_PAGES = (FB_ROWS + 7) / 8;

    logic [7:0] r_pos_x;
    logic [7:0] r_pos_y;
    logic [7:0] r_width;
    logic [7:0] r_height;
    logic [2:0] r_blend_mode;
    logic       r_pend_valid;
    logic       n_pend_valid;
    t_op        r_pend;
    t_op        n_pend;

    logic [9:0]  dc;
    logic [9:0]  top;
    logic [9:0]  y_b  [8];
    logic [8:0]  row_b[8];
    logic [7:0]  cov;
    logic        col_ok;
    logic [15:0] sh_d;
    logic [15:0] sh_m;
    logic        in_acc;
    t_op         op_lo;
    t_op         op_hi;
    t_op         op_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x      <= 8'd0;
            r_pos_y      <= 8'd0;
            r_width      <= 8'd8;
            r_height     <= 8'd8;
            r_blend_mode <= BLEND_REPLACE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POS_X:         r_pos_x      <= i_cfg_data;
                CFG_POS_Y:         r_pos_y      <= i_cfg_data;
                CFG_BITMAP_WIDTH:  r_width      <= i_cfg_data;
                CFG_BITMAP_HEIGHT: r_height     <= i_cfg_data;
                CFG_BLEND_MODE:    r_blend_mode <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_blend_mode = r_blend_mode;
    assign o_in_stall   = i_clearing || r_pend_valid || i_q_stat.full;
    assign in_acc       = i_in_valid && !o_in_stall;

    always_comb begin
        dc     = {{2{r_pos_x[7]}}, r_pos_x} + {2'b00, i_in_data.src_column};
        top    = {{2{r_pos_y[7]}}, r_pos_y} + {2'b00, i_in_data.src_page, 3'b000};
        col_ok = (i_in_data.src_column < r_width) && !dc[9] && (dc < 10'(FB_COLUMNS));
        for (int b = 0; b < 8; b++) begin
            y_b[b]   = top + 10'(b);
            row_b[b] = {1'b0, i_in_data.src_page, 3'b000} + 9'(b);
            cov[b]   = col_ok && (row_b[b] < {1'b0, r_height}) && !y_b[b][9]
                       && (y_b[b] < 10'(FB_ROWS));
        end
        sh_d = {8'd0, i_in_data.bitmap_byte} << top[2:0];
        sh_m = {8'd0, cov} << top[2:0];

        op_lo.is_read = 1'b0;
        op_lo.oob     = 1'b0;
        op_lo.page    = top[7:3];
        op_lo.column  = dc[7:0];
        op_lo.data    = sh_d[7:0];
        op_lo.mask    = sh_m[7:0];
        op_lo.last    = (sh_m[15:8] == 8'd0);

        op_hi.is_read = 1'b0;
        op_hi.oob     = 1'b0;
        op_hi.page    = top[7:3] + 5'd1;
        op_hi.column  = dc[7:0];
        op_hi.data    = sh_d[15:8];
        op_hi.mask    = sh_m[15:8];
        op_hi.last    = 1'b1;

        op_rd.is_read = 1'b1;
        op_rd.oob     = !(({2'b00, i_in_data.read_column} < 9'(FB_COLUMNS))
                          && ({3'b000, i_in_data.read_page} < 6'(FB_PAGES)));
        op_rd.page    = {2'b00, i_in_data.read_page};
        op_rd.column  = {1'b0, i_in_data.read_column};
        op_rd.data    = 8'd0;
        op_rd.mask    = 8'd0;
        op_rd.last    = 1'b1;
    end

    always_comb begin
        o_push.valid = 1'b0;
        o_push.op    = op_rd;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (r_pend_valid) begin
            o_push.op = r_pend;
            if (!i_q_stat.full) begin
                o_push.valid = 1'b1;
                n_pend_valid = 1'b0;
            end
        end else if (in_acc) begin
            if (i_in_data.action == ACT_READ) begin
                o_push.valid = 1'b1;
                o_push.op    = op_rd;
            end else if (op_lo.mask != 8'd0) begin
                o_push.valid = 1'b1;
                o_push.op    = op_lo;
                if (op_hi.mask != 8'd0) begin
                    n_pend_valid = 1'b1;
                    n_pend       = op_hi;
                end
            end else if (op_hi.mask != 8'd0) begin
                o_push.valid = 1'b1;
                o_push.op    = op_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

`default_nettype wire

### hw/rtl/pbb_queue.sv
// Short FIFO of byte operations between the front and back ends.
// Depends on pbb_pkg for the operation and status types.
`default_nettype none

module pbb_queue
    import pbb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_push i_push,
    input  wire logic    i_pop,
    output t_op          o_head,
    output t_q_stat      o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_op              r_entry[QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             push_en;
    logic             pop_en;

    assign o_stat.full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign push_en      = i_push.valid && !o_stat.full;
    assign pop_en       = i_pop && !o_stat.empty;
    assign o_head       = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_en && !pop_en) begin
                r_count <= r_count + 1'b1;
            end else if (pop_en && !push_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_entry[r_wr_ptr] <= i_push.op;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pbb_back.sv
// Back end: frame store, clearing pass, read-modify-write and output register.
// Depends on pbb_pkg and page_bitmap_blitter_assert.svh.
`default_nettype none

`include "page_bitmap_blitter_assert.svh"

module pbb_back
    import pbb_pkg::*;
#(
    parameter int FB_COLUMNS = FB_COLUMNS_DEF,
    parameter int FB_ROWS    = FB_ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_op        i_head,
    input  wire t_q_stat    i_q_stat,
    output logic            o_pop,
    output logic            o_clearing,
    input  wire logic [2:0] i_blend_mode,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out_item       o_data
);

    localparam int FB_PAGES  = (FB_ROWS + 7) / 8;
    localparam int MEM_DEPTH = FB_PAGES * FB_COLUMNS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_FETCH = 3'b010,
        ST_APPLY = 3'b100
    } t_state;

    logic [7:0]        mem[MEM_DEPTH];
    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] n_clr_addr;
    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_rdata;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [ADDR_W-1:0] head_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        new_byte;
    logic              out_free;
    logic              out_load;

    assign head_addr  = i_head.oob ? '0
                        : ADDR_W'(32'(i_head.page) * FB_COLUMNS + 32'(i_head.column));
    assign new_byte   = pbb_blend(i_blend_mode, r_rdata, r_op.data, r_op.mask);
    assign out_free   = !r_out_valid || !i_stall;
    assign o_clearing = (r_state == ST_CLEAR);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        o_pop      = 1'b0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_clr_addr;
        mem_wdata  = 8'd0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_FETCH;
                    if (!r_op.is_read) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_addr;
                        mem_wdata = new_byte;
                    end
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rdata <= mem[head_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op   <= i_head;
            r_addr <= head_addr;
        end
        if (out_load) begin
            r_out.fb_column   <= r_op.column[6:0];
            r_out.fb_page     <= r_op.page[2:0];
            r_out.fb_byte     <= r_op.is_read ? (r_op.oob ? 8'd0 : r_rdata) : new_byte;
            r_out.is_readback <= r_op.is_read;
            r_out.last        <= r_op.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `PBB_ASSERT_NOW(a_clear_queue_empty, r_state == ST_CLEAR, i_q_stat.empty, "queue filled during clear")
    `PBB_ASSERT_NEXT(a_apply_emits, r_state == ST_APPLY && out_free, r_state == ST_FETCH && r_out_valid, "apply did not emit")
    `PBB_ASSERT_NOW(a_oob_only_read, r_state == ST_APPLY && r_op.oob, r_op.is_read, "out-of-range flag on a blit")
    `PBB_ASSERT_NOW(a_clear_in_range, r_state == ST_CLEAR, r_clr_addr <= ADDR_W'(MEM_DEPTH - 1), "clear address past store")

endmodule

`default_nettype wire

### hw/rtl/page_bitmap_blitter.sv
// Page bitmap blitter: monochrome page-organized framebuffer with raster-op blits.
// Channels: input items on i_in_valid / o_in_stall / i_in_data, results on
//   o_out_valid / i_out_stall / o_out_data; an item moves when valid is high and
//   stall is low. Registers are written through i_cfg_we / i_cfg_index / i_cfg_data.
// A blit item yields zero, one or two written bytes (upper page first); a read
//   item yields one byte. last marks the final result of an item.
// Each framebuffer byte operation passes the queue, then ST_FETCH, which pops it
//   and reads the store, then ST_APPLY, which blends, writes back and loads the
//   output register from which the result is presented. A blit touching two
//   pages makes two byte operations, one touching one page or a read makes one.
// A four-entry operation queue lets the front accept items while the back works.
// After reset the store is zeroed, one byte per cycle, FB_PAGES * FB_COLUMNS
//   bytes (1024 at the default size); input is stalled meanwhile, register
//   writes are taken.
// When the receiver stalls, the result holds in the output register, the back end
//   halts and the queue then fills until input is stalled.
// Depends on pbb_pkg, pbb_front, pbb_queue, pbb_back.
`default_nettype none

module page_bitmap_blitter
    import pbb_pkg::*;
#(
    parameter int FB_COLUMNS = FB_COLUMNS_DEF,
    parameter int FB_ROWS    = FB_ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data
);

    t_q_push    push;
    t_q_stat    q_stat;
    t_op        head;
    logic       pop;
    logic       clearing;
    logic [2:0] blend_mode;

    pbb_front #(
        .FB_COLUMNS (FB_COLUMNS),
        .FB_ROWS    (FB_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_clearing   (clearing),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_blend_mode (blend_mode)
    );

    pbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    pbb_back #(
        .FB_COLUMNS (FB_COLUMNS),
        .FB_ROWS    (FB_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .i_blend_mode (blend_mode),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_data       (o_out_data)
    );

endmodule

`default_nettype wire

### tb/tb_page_bitmap_blitter.sv
// Self-checking testbench for page_bitmap_blitter: directed table, then random blits and reads,
// checked against a shadow framebuffer with the block's clipping and raster ops.
// Depends on pbb_pkg and the page_bitmap_blitter RTL only.
`timescale 1ns / 100ps

module tb_page_bitmap_blitter;
    import pbb_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int LIMIT_CYCLES  = 500_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int FB_COLS       = FB_COLUMNS_DEF;
    localparam int FB_ROWS       = FB_ROWS_DEF;
    localparam int FB_PAGES      = (FB_ROWS + 7) / 8;
    localparam int RAND_PHASES   = 21;
    localparam int PHASE_ITEMS   = 50;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic [1:0] {ROW_CFG, ROW_BLIT, ROW_READ} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] pixels;
        logic       typed;
        logic [7:0] want_byte;
    } t_plan_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [2:0] cfg_index = CFG_POS_X;
    logic [7:0] cfg_data  = 8'h00;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    logic [7:0] shadow_fb [FB_PAGES][FB_COLS];
    int         sh_pos_x  = 0;
    int         sh_pos_y  = 0;
    int         sh_width  = 8;
    int         sh_height = 8;
    logic [2:0] sh_mode   = BLEND_REPLACE;

    t_out_item  pending_bytes[$];
    t_plan_row  plan[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int items_sent    = 0;
    int bytes_checked = 0;
    int settings_used = 0;

    page_bitmap_blitter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [7:0] blend_bits(input logic [2:0] mode, input logic [7:0] o,
                                              input logic [7:0] d, input logic [7:0] m);
        logic [7:0] f;
        case (mode)
            BLEND_OR:    f = o | d;
            BLEND_ERASE: f = o & ~d;
            BLEND_XOR:   f = o ^ d;
            BLEND_AND:   f = o & d;
            BLEND_NOT:   f = o | ~d;
            BLEND_XNOR:  f = ~(o ^ d);
            default:     f = d;
        endcase
        return (o & ~m) | (f & m);
    endfunction

    function automatic int predict_fb_bytes(input t_in_item it);
        int         col;
        int         row;
        int         y;
        int         used;
        logic [2:0] pg  [2];
        logic [7:0] msk [2];
        logic [7:0] dat [2];
        t_out_item  res;
        used = 0;
        if (it.action == ACT_READ) begin
            res.fb_column   = it.read_column;
            res.fb_page     = it.read_page;
            res.fb_byte     = (int'(it.read_column) < FB_COLS && int'(it.read_page) < FB_PAGES)
                              ? shadow_fb[it.read_page][it.read_column] : 8'h00;
            res.is_readback = 1'b1;
            res.last        = 1'b1;
            pending_bytes.push_back(res);
            return 1;
        end
        col = sh_pos_x + int'(it.src_column);
        if (int'(it.src_column) >= sh_width || col < 0 || col >= FB_COLS)
            return 0;
        for (int b = 0; b < 8; b++) begin
            row = int'(it.src_page) * 8 + b;
            y   = sh_pos_y + row;
            if (row < sh_height && y >= 0 && y < FB_ROWS) begin
                if (used == 0) begin
                    pg[0]  = 3'(y / 8);
                    msk[0] = 8'h00;
                    dat[0] = 8'h00;
                    used   = 1;
                end else if (int'(pg[used - 1]) != y / 8) begin
                    pg[used]  = 3'(y / 8);
                    msk[used] = 8'h00;
                    dat[used] = 8'h00;
                    used++;
                end
                msk[used - 1][y % 8] = 1'b1;
                dat[used - 1][y % 8] = it.bitmap_byte[b];
            end
        end
        for (int k = 0; k < used; k++) begin
            shadow_fb[pg[k]][col] = blend_bits(sh_mode, shadow_fb[pg[k]][col], dat[k], msk[k]);
            res.fb_column   = 7'(col);
            res.fb_page     = pg[k];
            res.fb_byte     = shadow_fb[pg[k]][col];
            res.is_readback = 1'b0;
            res.last        = (k == used - 1);
            pending_bytes.push_back(res);
        end
        return used;
    endfunction

    function automatic t_plan_row mk_row(input t_row_kind kind, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] pixels,
                                         input logic typed, input logic [7:0] want_byte);
        t_plan_row r;
        r.kind      = kind;
        r.a         = a;
        r.b         = b;
        r.pixels    = pixels;
        r.typed     = typed;
        r.want_byte = want_byte;
        return r;
    endfunction

    function automatic int pick_value(input int lo, input int hi, input int useful);
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return useful;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       sel;
        int       c;
        int       tgt;
        it  = t_in_item'($urandom);
        sel = $urandom_range(99);
        if (sel < 10)
            return it;
        if (sel < 35) begin
            it.action = ACT_READ;
            return it;
        end
        it.action = ACT_BLIT;
        c = $urandom_range(FB_COLS - 1) - sh_pos_x;
        if (c >= 0 && c <= 255)
            it.src_column = 8'(c);
        tgt = $urandom_range(FB_ROWS - 1) - sh_pos_y;
        if (tgt >= 0 && tgt / 8 <= 31)
            it.src_page = 5'(tgt / 8);
        return it;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 37;
                recv_idle_pct = 66;
            end
            1: begin
                send_idle_pct = 66;
                recv_idle_pct = 37;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_POS_X:         sh_pos_x  = int'($signed(val));
            CFG_POS_Y:         sh_pos_y  = int'($signed(val));
            CFG_BITMAP_WIDTH:  sh_width  = int'(val);
            CFG_BITMAP_HEIGHT: sh_height = int'(val);
            CFG_BLEND_MODE:    sh_mode   = val[2:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_item(input t_in_item it, output int n);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        n = predict_fb_bytes(it);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $write("%0t: %s: want col %0d page %0d byte %02h rb %0b last %0b, ",
                   $time, what, want.fb_column, want.fb_page, want.fb_byte,
                   want.is_readback, want.last);
            $display("got col %0d page %0d byte %02h rb %0b last %0b",
                     got.fb_column, got.fb_page, got.fb_byte, got.is_readback, got.last);
        end
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("unexpected result", '0, out_data);
            end else begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (out_data.fb_column !== want.fb_column || out_data.fb_page !== want.fb_page ||
                    out_data.fb_byte !== want.fb_byte ||
                    out_data.is_readback !== want.is_readback || out_data.last !== want.last)
                    report_mismatch("mismatch", want, out_data);
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_plan_row r;
        t_in_item  it;
        t_out_item want;
        int        n;
        logic      in_cfg;
        foreach (shadow_fb[p, c])
            shadow_fb[p][c] = 8'h00;

        // store cleared, registers at reset values
        plan.push_back(mk_row(ROW_READ,   0, 0, 8'h00, 1, 8'h00));
        plan.push_back(mk_row(ROW_READ, 127, 7, 8'h00, 1, 8'h00));
        plan.push_back(mk_row(ROW_BLIT,   0, 0, 8'hA5, 1, 8'hA5));
        plan.push_back(mk_row(ROW_READ,   0, 0, 8'h00, 1, 8'hA5));
        plan.push_back(mk_row(ROW_BLIT,   7, 0, 8'hFF, 1, 8'hFF));
        // clip on bitmap width, then on bitmap height
        plan.push_back(mk_row(ROW_BLIT,   8, 0, 8'hFF, 0, 8'h00));
        plan.push_back(mk_row(ROW_BLIT,   0, 1, 8'hFF, 0, 8'h00));
        // unused mode behaves as replace
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BLEND_MODE), 8'h07, 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   0, 0, 8'h3C, 1, 8'h3C));
        // straddle two pages, one blit per raster op other than replace
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_POS_Y), 8'h03, 0, 0, 0));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BITMAP_WIDTH), 8'hFF, 0, 0, 0));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BITMAP_HEIGHT), 8'hFF, 0, 0, 0));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BLEND_MODE), 8'(BLEND_OR), 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   0, 0, 8'hFF, 0, 8'h00));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BLEND_MODE), 8'(BLEND_ERASE), 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   0, 0, 8'h0F, 0, 8'h00));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BLEND_MODE), 8'(BLEND_XOR), 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   7, 0, 8'hAA, 0, 8'h00));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BLEND_MODE), 8'(BLEND_AND), 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   7, 0, 8'h55, 0, 8'h00));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BLEND_MODE), 8'(BLEND_NOT), 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   1, 0, 8'h0F, 0, 8'h00));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BLEND_MODE), 8'(BLEND_XNOR), 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   1, 0, 8'hF0, 0, 8'h00));
        // most negative position
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BLEND_MODE), 8'(BLEND_REPLACE), 0, 0, 0));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_POS_X), 8'h80, 0, 0, 0));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_POS_Y), 8'h80, 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT, 255, 17, 8'hC3, 0, 8'h00));
        plan.push_back(mk_row(ROW_BLIT, 255, 31, 8'hC3, 0, 8'h00));
        // most positive position: off screen
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_POS_X), 8'h7F, 0, 0, 0));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_POS_Y), 8'h7F, 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   0, 0, 8'hFF, 0, 8'h00));
        plan.push_back(mk_row(ROW_BLIT,   1, 0, 8'hFF, 0, 8'h00));
        // bottom edge, then zero height, a height of five and zero width
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_POS_X), 8'h00, 0, 0, 0));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_POS_Y), 8'd60, 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   5, 0, 8'hFF, 0, 8'h00));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BITMAP_HEIGHT), 8'h00, 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   5, 0, 8'hFF, 0, 8'h00));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BITMAP_HEIGHT), 8'd5, 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   6, 0, 8'hFF, 0, 8'h00));
        plan.push_back(mk_row(ROW_CFG, 8'(CFG_BITMAP_WIDTH), 8'h00, 0, 0, 0));
        plan.push_back(mk_row(ROW_BLIT,   0, 0, 8'hFF, 0, 8'h00));
        plan.push_back(mk_row(ROW_READ, 127, 7, 8'h00, 0, 8'h00));
        plan.push_back(mk_row(ROW_READ,   0, 1, 8'h00, 0, 8'h00));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(0);
        in_cfg = 1'b1;
        settings_used = 1;

        foreach (plan[i]) begin
            r = plan[i];
            if (r.kind == ROW_CFG) begin
                if (!in_cfg) begin
                    drain();
                    settings_used++;
                end
                write_reg(r.a[2:0], r.b);
                in_cfg = 1'b1;
            end else begin
                if (in_cfg)
                    cfg_we <= 1'b0;
                in_cfg = 1'b0;
                it = t_in_item'($urandom);
                if (r.kind == ROW_READ) begin
                    it.action      = ACT_READ;
                    it.read_column = r.a[6:0];
                    it.read_page   = r.b[2:0];
                end else begin
                    it.action      = ACT_BLIT;
                    it.src_column  = r.a;
                    it.src_page    = r.b[4:0];
                    it.bitmap_byte = r.pixels;
                end
                send_item(it, n);
                if (r.typed) begin
                    want.fb_column   = r.a[6:0];
                    want.fb_page     = r.b[2:0];
                    want.fb_byte     = r.want_byte;
                    want.is_readback = (r.kind == ROW_READ);
                    want.last        = 1'b1;
                    pending_bytes[pending_bytes.size() - 1] = want;
                end
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            set_idling(ph * 3 / RAND_PHASES);
            write_reg(CFG_POS_X, 8'(pick_value(-128, 127, $urandom_range(143) - 16)));
            write_reg(CFG_POS_Y, 8'(pick_value(-128, 127, $urandom_range(79) - 16)));
            write_reg(CFG_BITMAP_WIDTH, 8'(pick_value(0, 255, $urandom_range(4, 255))));
            write_reg(CFG_BITMAP_HEIGHT, 8'(pick_value(0, 255, $urandom_range(4, 255))));
            write_reg(CFG_BLEND_MODE, 8'($urandom_range(7)));
            cfg_we <= 1'b0;
            settings_used++;
            repeat (PHASE_ITEMS) send_item(random_item(), n);
        end
        drain();

        $display("Run covered %0d items over %0d register settings and three idling patterns.",
                 items_sent, settings_used);
        $display("Compared %0d result bytes, %0d discrepancies.", bytes_checked, mismatches);
        if (mismatches == 0 && pending_bytes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
